[src/teleop_deadman_estop_controller_macros.svh]
// Assertion macros shared by the teleop controller RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef TELEOP_DEADMAN_ESTOP_CONTROLLER_MACROS_SVH
`define TELEOP_DEADMAN_ESTOP_CONTROLLER_MACROS_SVH

// Checked only outside reset.
`define TDESC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define TDESC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/tdesc_pkg.sv]
// Shared types and constants for the teleop deadman / e-stop controller.
// No dependencies; used by tdesc_decode and the top level.
package tdesc_pkg;

  typedef enum logic [2:0] {
    INTENT_NONE    = 3'd0,
    INTENT_MOTION  = 3'd1,
    INTENT_SOFT    = 3'd2,
    INTENT_ESTOP   = 3'd3,
    INTENT_RESET   = 3'd4,
    INTENT_EXIT    = 3'd5,
    INTENT_DEADMAN = 3'd6,
    INTENT_BLOCKED = 3'd7
  } intent_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FWD_SPEED  = 3'd0;
  localparam logic [2:0] CFG_TURN_SPEED = 3'd1;
  localparam logic [2:0] CFG_FWD_LIMIT  = 3'd2;
  localparam logic [2:0] CFG_TURN_LIMIT = 3'd3;
  localparam logic [2:0] CFG_HOLD_TMO   = 3'd4;

  localparam logic [14:0] SPEED_RESET = 15'd0;
  localparam logic [14:0] LIMIT_RESET = 15'd32767;
  localparam logic [15:0] HOLD_RESET  = 16'd500;

  // Lower-case key bytes after folding, plus space and the upper-case fold range bounds.
  localparam logic [7:0] KEY_X     = 8'h78;
  localparam logic [7:0] KEY_R     = 8'h72;
  localparam logic [7:0] KEY_Q     = 8'h71;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [7:0] KEY_W     = 8'h77;
  localparam logic [7:0] KEY_S     = 8'h73;
  localparam logic [7:0] KEY_A     = 8'h61;
  localparam logic [7:0] KEY_D     = 8'h64;
  localparam logic [7:0] KEY_UPPER_A = 8'h41;
  localparam logic [7:0] KEY_UPPER_Z = 8'h5A;

  typedef struct packed {
    logic [14:0] fwd_speed;
    logic [14:0] turn_speed;
    logic [14:0] fwd_limit;
    logic [14:0] turn_limit;
    logic [15:0] hold_tmo;
  } cfg_t;

  typedef struct packed {
    logic        estop;
    logic        moving;
    logic [15:0] lin;
    logic [15:0] ang;
    logic [31:0] last_time;
  } state_t;

  typedef struct packed {
    intent_e     intent;
    logic [15:0] lin;
    logic [15:0] ang;
    logic        known;
    logic        latched;
  } res_t;

endpackage

[src/tdesc_decode.sv]
// Single-pass decode of one key or tick beat against the current controller state.
// Depends on tdesc_pkg for the config, state and result types.
module tdesc_decode (
  input  logic             mode_i,
  input  logic [7:0]       key_code_i,
  input  logic [31:0]      time_ms_i,
  input  tdesc_pkg::cfg_t   cfg_i,
  input  tdesc_pkg::state_t st_i,
  output tdesc_pkg::state_t st_o,
  output tdesc_pkg::res_t   res_o
);
  import tdesc_pkg::*;

  logic [7:0]  key_fold;
  logic [31:0] elapsed;
  logic        timed_out;
  logic [14:0] lin_mag;
  logic [14:0] ang_mag;
  logic        is_motion;
  intent_e     intent;
  logic        known;

  assign key_fold  = (key_code_i >= KEY_UPPER_A && key_code_i <= KEY_UPPER_Z) ?
                     (key_code_i | 8'h20) : key_code_i;
  // Wrapping difference, so a counter rollover between motion and tick is harmless.
  assign elapsed   = time_ms_i - st_i.last_time;
  assign timed_out = st_i.moving && (elapsed >= {16'd0, cfg_i.hold_tmo});
  assign lin_mag   = (cfg_i.fwd_speed < cfg_i.fwd_limit) ? cfg_i.fwd_speed : cfg_i.fwd_limit;
  assign ang_mag   = (cfg_i.turn_speed < cfg_i.turn_limit) ? cfg_i.turn_speed : cfg_i.turn_limit;
  assign is_motion = (key_fold == KEY_W) || (key_fold == KEY_S) ||
                     (key_fold == KEY_A) || (key_fold == KEY_D);

  always_comb begin
    st_o   = st_i;
    intent = INTENT_NONE;
    known  = 1'b0;
    if (mode_i) begin
      if (timed_out) begin
        st_o.lin    = 16'd0;
        st_o.ang    = 16'd0;
        st_o.moving = 1'b0;
        intent      = INTENT_DEADMAN;
        known       = 1'b1;
      end
    end else begin
      priority if (key_fold == KEY_X) begin
        st_o.estop  = 1'b1;
        st_o.lin    = 16'd0;
        st_o.ang    = 16'd0;
        st_o.moving = 1'b0;
        intent      = INTENT_ESTOP;
        known       = 1'b1;
      end else if (key_fold == KEY_R) begin
        st_o.estop  = 1'b0;
        st_o.lin    = 16'd0;
        st_o.ang    = 16'd0;
        st_o.moving = 1'b0;
        intent      = INTENT_RESET;
        known       = 1'b1;
      end else if (key_fold == KEY_Q || key_code_i == KEY_SPACE) begin
        st_o.lin    = 16'd0;
        st_o.ang    = 16'd0;
        st_o.moving = 1'b0;
        intent      = (key_fold == KEY_Q) ? INTENT_EXIT : INTENT_SOFT;
        known       = 1'b1;
      end else if (is_motion && st_i.estop) begin
        st_o.lin    = 16'd0;
        st_o.ang    = 16'd0;
        st_o.moving = 1'b0;
        intent      = INTENT_BLOCKED;
        known       = 1'b1;
      end else if (is_motion) begin
        st_o.moving    = 1'b1;
        st_o.last_time = time_ms_i;
        st_o.lin       = 16'd0;
        st_o.ang       = 16'd0;
        intent         = INTENT_MOTION;
        known          = 1'b1;
        if (key_fold == KEY_W) begin
          st_o.lin = {1'b0, lin_mag};
        end else if (key_fold == KEY_S) begin
          st_o.lin = 16'd0 - {1'b0, lin_mag};
        end else if (key_fold == KEY_A) begin
          st_o.ang = {1'b0, ang_mag};
        end else begin
          st_o.ang = 16'd0 - {1'b0, ang_mag};
        end
      end else begin
        intent = INTENT_NONE;
        known  = 1'b0;
      end
    end
  end

  assign res_o.intent  = intent;
  assign res_o.lin     = st_o.lin;
  assign res_o.ang     = st_o.ang;
  assign res_o.known   = known;
  assign res_o.latched = st_o.estop;

endmodule

[src/teleop_deadman_estop_controller.sv]
// Top level of the teleop key decoder with e-stop latch and deadman timer.
// Depends on tdesc_pkg, tdesc_decode and the shared assertion macro header.
//
// Every input beat (a key event or a deadman tick, with a millisecond timestamp)
// gives exactly one registered result beat. The decode is a single pass of compare
// and select logic plus one 32-bit subtract/compare for the deadman check, so a new
// beat is taken every cycle while the skid register is empty. Results leave through an
// output register backed by a one-entry skid register; s_axis_tready depends only
// on the skid register, so up to two results may wait for the downstream side
// before input stalls. Configuration writes take effect on the next beat.
`include "teleop_deadman_estop_controller_macros.svh"

module teleop_deadman_estop_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // key_code [7:0], time_ms [39:8]
  input  logic        s_axis_tuser,   // mode (0 key, 1 tick)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // lin_cmd [15:0], ang_cmd [31:16],
                                      // key_known [32], stop_latched [33], zero [39:34]
  output logic [2:0]  m_axis_tuser    // intent_code
);
  import tdesc_pkg::*;

  cfg_t   cfg_q;
  state_t st_q;
  state_t st_d;
  res_t   res;
  res_t   out_q;
  res_t   skid_q;
  logic   out_valid_q;
  logic   skid_valid_q;
  logic   accept;
  logic   pop;

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid_q && m_axis_tready;

  tdesc_decode u_decode (
    .mode_i     (s_axis_tuser),
    .key_code_i (s_axis_tdata[7:0]),
    .time_ms_i  (s_axis_tdata[39:8]),
    .cfg_i      (cfg_q),
    .st_i       (st_q),
    .st_o       (st_d),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fwd_speed  <= SPEED_RESET;
      cfg_q.turn_speed <= SPEED_RESET;
      cfg_q.fwd_limit  <= LIMIT_RESET;
      cfg_q.turn_limit <= LIMIT_RESET;
      cfg_q.hold_tmo   <= HOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FWD_SPEED:  cfg_q.fwd_speed  <= cfg_data_i[14:0];
        CFG_TURN_SPEED: cfg_q.turn_speed <= cfg_data_i[14:0];
        CFG_FWD_LIMIT:  cfg_q.fwd_limit  <= cfg_data_i[14:0];
        CFG_TURN_LIMIT: cfg_q.turn_limit <= cfg_data_i[14:0];
        CFG_HOLD_TMO:   cfg_q.hold_tmo   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  // Output register plus skid: a beat taken while the output is stalled parks in skid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.intent;
  assign m_axis_tdata  = {6'd0, out_q.latched, out_q.known, out_q.ang, out_q.lin};

  `TDESC_ASSERT_ALWAYS(a_skid_implies_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
  `TDESC_ASSERT_ALWAYS(a_idle_zero_vel, !st_q.moving |-> (st_q.lin == 16'd0 && st_q.ang == 16'd0), "velocity held while not moving")
  `TDESC_ASSERT(a_estop_latches, (accept && res.intent == INTENT_ESTOP) |=> st_q.estop, "estop key did not set the latch")
  `TDESC_ASSERT(a_motion_unlatched, (out_valid_q && out_q.intent == INTENT_MOTION) |-> !out_q.latched, "motion reported while latched")
  `TDESC_ASSERT(a_stall_holds_out, (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_q)), "stalled result changed")

endmodule
